### src/pese_pkg.sv
// ----------------------------------------------------------------------------
// pese_pkg
// Shared types and constants of the prefix expression stack evaluator:
// action and status codes, controller states and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package pese_pkg;

  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int ST_W   = 2;

  // Action codes carried on the input tuser
  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FINISH = 3'd5;

  // Status codes carried on the output tuser
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_DIVZERO = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_R,
    S_GRAB_R,
    S_CALC,
    S_DIV,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;     // latch the accepted token
    logic pop;         // read the top entry and shrink the stack
    logic grab_left;   // capture the first popped word
    logic grab_right;  // capture the second popped word
    logic calc;        // evaluate add, subtract, multiply or a zero divide
    logic div_go;      // start the serial divider
    logic emit;        // commit the stack write and load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             right_zero;
    logic             div_done;
    logic             out_free;
  } sts_t;

endpackage

### src/pese_div.sv
// ----------------------------------------------------------------------------
// pese_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Operand magnitudes are taken at start; the sign is applied on the output.
// ----------------------------------------------------------------------------
module pese_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pese_pkg::DATA_W-1:0]   dividend,
  input  logic [pese_pkg::DATA_W-1:0]   divisor,
  output logic                          done,
  output logic [pese_pkg::DATA_W-1:0]   quotient
);

  localparam int W  = pese_pkg::DATA_W;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [W-1:0]  q;
  logic [W-1:0]  rem;
  logic [W-1:0]  mb;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // Trial subtract of the divisor from the shifted remainder
  assign shifted = {rem, q[W-1]};
  assign diff    = shifted - {1'b0, mb};

  // Apply the sign to the magnitude quotient
  assign quotient = neg ? (W'(0) - q) : q;

  // Control: busy flag, step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CW'(W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: load magnitudes, then shift and subtract one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[W-1] ^ divisor[W-1];
      q   <= dividend[W-1] ? (W'(0) - dividend) : dividend;
      mb  <= divisor[W-1] ? (W'(0) - divisor) : divisor;
      rem <= '0;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        q   <= {q[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        q   <= {q[W-2:0], 1'b0};
      end
    end
  end

endmodule

### src/pese_ctrl.sv
// ----------------------------------------------------------------------------
// pese_ctrl
// Controller of the evaluator: sequences token intake, stack pops, the
// arithmetic step and the result transfer.
// ----------------------------------------------------------------------------
module pese_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  pese_pkg::sts_t    sts,
  output pese_pkg::cmd_t    cmd
);

  pese_pkg::state_t state;
  pese_pkg::state_t state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pese_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      pese_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take_in = 1'b1;
          state_next  = pese_pkg::S_DECODE;
        end
      end
      pese_pkg::S_DECODE: begin
        case (sts.act)
          pese_pkg::ACT_ADD, pese_pkg::ACT_SUB, pese_pkg::ACT_MUL,
          pese_pkg::ACT_DIV, pese_pkg::ACT_FINISH: begin
            cmd.pop    = 1'b1;
            state_next = pese_pkg::S_POP_R;
          end
          default: begin
            state_next = pese_pkg::S_EMIT;
          end
        endcase
      end
      pese_pkg::S_POP_R: begin
        cmd.grab_left = 1'b1;
        if (sts.act == pese_pkg::ACT_FINISH) begin
          state_next = pese_pkg::S_EMIT;
        end else begin
          cmd.pop    = 1'b1;
          state_next = pese_pkg::S_GRAB_R;
        end
      end
      pese_pkg::S_GRAB_R: begin
        cmd.grab_right = 1'b1;
        state_next     = pese_pkg::S_CALC;
      end
      pese_pkg::S_CALC: begin
        cmd.calc = 1'b1;
        if (sts.act == pese_pkg::ACT_DIV && !sts.right_zero) begin
          cmd.div_go = 1'b1;
          state_next = pese_pkg::S_DIV;
        end else begin
          state_next = pese_pkg::S_EMIT;
        end
      end
      pese_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_next = pese_pkg::S_EMIT;
        end
      end
      pese_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = pese_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pese_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/pese_dp.sv
// ----------------------------------------------------------------------------
// pese_dp
// Datapath of the evaluator: operand stack memory and count, popped operand
// registers, multiplier, serial divider and the output register.
// ----------------------------------------------------------------------------
module pese_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pese_pkg::cmd_t                    cmd,
  output pese_pkg::sts_t                    sts,
  input  logic [pese_pkg::DATA_W-1:0]       s_tdata,
  input  logic [pese_pkg::ACT_W-1:0]        s_tuser,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [pese_pkg::DATA_W-1:0]       m_tdata,
  output logic [pese_pkg::ST_W-1:0]         m_tuser,
  output logic                              m_tlast
);

  localparam int W  = pese_pkg::DATA_W;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [W-1:0]                 mem [STACK_DEPTH];
  logic [W-1:0]                 rd_data;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_m1;
  logic                         full;
  logic                         pop_ok;
  logic [pese_pkg::ACT_W-1:0]   act;
  logic [W-1:0]                 opnd;
  logic [W-1:0]                 left;
  logic [W-1:0]                 right;
  logic                         ok1;
  logic                         ok2;
  logic [W-1:0]                 res;
  logic                         divzero;
  logic                         div_done;
  logic [W-1:0]                 div_q;
  logic                         wr_en;
  logic [W-1:0]                 wr_data;
  logic [pese_pkg::ST_W-1:0]    st_val;
  logic [W-1:0]                 out_val;
  logic                         out_last;

  assign count_m1 = count - CW'(1);
  assign full     = (count == CW'(STACK_DEPTH));

  // Status towards the controller
  assign sts.act        = act;
  assign sts.right_zero = (right == '0);
  assign sts.div_done   = div_done;
  assign sts.out_free   = !m_tvalid || m_tready;

  pese_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (left),
    .divisor  (right),
    .done     (div_done),
    .quotient (div_q)
  );

  // Form the result and the stack write for the current token
  always_comb begin
    wr_en    = 1'b0;
    wr_data  = res;
    st_val   = pese_pkg::ST_OK;
    out_val  = '0;
    out_last = 1'b0;
    case (act)
      pese_pkg::ACT_PUSH: begin
        wr_en   = cmd.emit && !full;
        wr_data = opnd;
        out_val = opnd;
        st_val  = full ? pese_pkg::ST_FULL : pese_pkg::ST_OK;
      end
      pese_pkg::ACT_ADD, pese_pkg::ACT_SUB, pese_pkg::ACT_MUL, pese_pkg::ACT_DIV: begin
        wr_en   = cmd.emit;
        out_val = res;
        if (!(ok1 && ok2)) begin
          st_val = pese_pkg::ST_EMPTY;
        end else if (divzero) begin
          st_val = pese_pkg::ST_DIVZERO;
        end
      end
      pese_pkg::ACT_FINISH: begin
        out_val  = left;
        out_last = 1'b1;
        st_val   = ok1 ? pese_pkg::ST_OK : pese_pkg::ST_EMPTY;
      end
      default: begin
        out_val = '0;
      end
    endcase
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= wr_data;
    end
    if (cmd.pop) begin
      rd_data <= mem[count_m1[AW-1:0]];
    end
  end

  // Stack count and pop outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      pop_ok <= 1'b0;
    end else begin
      if (cmd.pop) begin
        pop_ok <= (count != '0);
        if (count != '0) begin
          count <= count_m1;
        end
      end else if (wr_en) begin
        count <= count + CW'(1);
      end
    end
  end

  // Token, popped operands and arithmetic result
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      act  <= s_tuser;
      opnd <= s_tdata;
    end
    if (cmd.grab_left) begin
      ok1  <= pop_ok;
      left <= pop_ok ? rd_data : '0;
    end
    if (cmd.grab_right) begin
      ok2   <= pop_ok;
      right <= pop_ok ? rd_data : '0;
    end
    if (cmd.calc) begin
      divzero <= (act == pese_pkg::ACT_DIV) && (right == '0);
      case (act)
        pese_pkg::ACT_ADD: res <= left + right;
        pese_pkg::ACT_SUB: res <= left - right;
        pese_pkg::ACT_MUL: res <= left * right;
        default:           res <= '0;
      endcase
    end else if (div_done) begin
      res <= div_q;
    end
  end

  // Output register: hold until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= out_val;
      m_tuser <= st_val;
      m_tlast <= out_last;
    end
  end

endmodule

### src/prefix_expression_stack_evaluator.sv
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator
// Evaluates prefix expressions from parsed tokens on an operand stack.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens arrive on the s_ channel in right-to-left scan order of a prefix
//   expression: tuser carries the action (push, add, subtract, multiply,
//   divide, finish) and tdata the signed operand of a push. Every token gives
//   exactly one transfer on the m_ channel: tdata holds the value pushed,
//   computed or finally popped, tuser the status (ok, stack full, stack
//   empty, divide by zero) and tlast marks the result of a finish token.
//   One token is worked at a time. After acceptance a push or an unknown
//   action is decoded and emitted; finish pops once and add, subtract,
//   multiply and a zero divisor pop twice and compute before the emit;
//   a divide by a non-zero divisor also waits for the serial divider at
//   one quotient bit per cycle over 32 shift steps. The next token is
//   taken once the result is in the output register, where it may still
//   wait for the receiver. When the receiver stalls, the result is held
//   and a later token waits in its final step until the register frees.
//   Reset empties the stack and drops any pending result; stack words need
//   no clearing since each is written before it is read.
// ----------------------------------------------------------------------------
module prefix_expression_stack_evaluator #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pese_pkg::DATA_W-1:0]   s_tdata,   // [31:0] operand
  input  logic [pese_pkg::ACT_W-1:0]    s_tuser,   // [2:0] action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pese_pkg::DATA_W-1:0]   m_tdata,   // [31:0] value
  output logic [pese_pkg::ST_W-1:0]     m_tuser,   // [1:0] status
  output logic                          m_tlast    // done_res
);

  pese_pkg::cmd_t cmd;
  pese_pkg::sts_t sts;

  pese_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pese_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### src/pese_checker.sv
// ----------------------------------------------------------------------------
// pese_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pese_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pese_pkg::DATA_W-1:0]   m_tdata,
  input logic [pese_pkg::ST_W-1:0]     m_tuser,
  input logic                          m_tlast
);

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // One token at a time: intake closes after a transfer in
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second token taken while one is in work");

  // A finish result never reports full stack or divide by zero
  a_finish_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |->
      (m_tuser == pese_pkg::ST_OK || m_tuser == pese_pkg::ST_EMPTY))
    else $error("bad status on finish result");

  // A finish on an empty stack reads zero
  a_empty_finish: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tuser == pese_pkg::ST_EMPTY |-> m_tdata == '0)
    else $error("empty finish returned non-zero value");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind prefix_expression_stack_evaluator pese_checker u_pese_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### test/prefix_expression_stack_evaluator_test.sv
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator_test
// Self-checking bench for the prefix expression stack evaluator. Tokens are
// driven on the slave stream and mirrored in a local stack model, which works
// out the status, value and last flag of every transfer expected on the
// master stream. Directed tests cover empty and full stacks, wrapping
// arithmetic, truncating and zero division and unknown actions. A long
// receiver hold fills the block, and randomly shaped expressions with noise
// tokens follow. Both streams idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module prefix_expression_stack_evaluator_test;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W      = pese_pkg::DATA_W;
  localparam int ACT_W       = pese_pkg::ACT_W;
  localparam int ST_W        = pese_pkg::ST_W;

  // Action codes the block must ignore
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] WORD_M1  = 32'hffff_ffff;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] value;
    logic              last;
  } eval_result_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;   // [31:0] operand
  logic [ACT_W-1:0]  s_tuser  = pese_pkg::ACT_PUSH; // [2:0] action
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;         // [31:0] value
  logic [ST_W-1:0]   m_tuser;         // [1:0] status
  logic              m_tlast;

  // Local copy of the operand stack
  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int                model_depth = 0;

  eval_result_t      pending_results [$];
  eval_result_t      rx_want;
  bit                mismatch_seen = 1'b0;
  int                tokens_sent = 0;

  bit                tx_idle_on = 1'b0;
  bit                rx_idle_on = 1'b0;
  int                rx_stall_left = 0;
  int                rx_hold_request = 0;

  prefix_expression_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
    if (r < 42) begin
      case ($urandom_range(0, 4))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return '0;
        3: return DATA_W'(1);
        default: return WORD_M1;
      endcase
    end
    return $urandom;
  endfunction

  // Pop from the model; an empty stack reads zero
  function automatic bit pop_model(output logic [DATA_W-1:0] word);
    if (model_depth == 0) begin
      word = '0;
      return 1'b0;
    end
    model_depth--;
    word = model_stack[model_depth];
    return 1'b1;
  endfunction

  // Apply one token to the model and return the transfer it should produce
  function automatic eval_result_t evaluate_token(logic [ACT_W-1:0] act,
                                                  logic [DATA_W-1:0] opnd);
    eval_result_t      r;
    logic [DATA_W-1:0] left, right, mag_l, mag_r, quot;
    bit                got_l, got_r;
    r = '{pese_pkg::ST_OK, '0, 1'b0};
    case (act)
      pese_pkg::ACT_PUSH: begin
        r.value = opnd;
        if (model_depth < STACK_DEPTH) begin
          model_stack[model_depth] = opnd;
          model_depth++;
        end else begin
          r.status = pese_pkg::ST_FULL;
        end
      end
      pese_pkg::ACT_ADD, pese_pkg::ACT_SUB, pese_pkg::ACT_MUL, pese_pkg::ACT_DIV: begin
        // first pop is the left operand, second the right
        got_l = pop_model(left);
        got_r = pop_model(right);
        case (act)
          pese_pkg::ACT_ADD: r.value = left + right;
          pese_pkg::ACT_SUB: r.value = left - right;
          pese_pkg::ACT_MUL: r.value = left * right;
          default: begin
            if (right == '0) begin
              r.value  = '0;
              r.status = pese_pkg::ST_DIVZERO;
            end else begin
              mag_l   = left[DATA_W-1] ? -left : left;
              mag_r   = right[DATA_W-1] ? -right : right;
              quot    = mag_l / mag_r;
              r.value = (left[DATA_W-1] ^ right[DATA_W-1]) ? -quot : quot;
            end
          end
        endcase
        // the pops always leave room for the result
        model_stack[model_depth] = r.value;
        model_depth++;
        if (!got_l || !got_r) r.status = pese_pkg::ST_EMPTY;
      end
      pese_pkg::ACT_FINISH: begin
        if (!pop_model(r.value)) r.status = pese_pkg::ST_EMPTY;
        r.last = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one token, hold it until the transfer, then predict its result
  task automatic send_token(logic [ACT_W-1:0] act, logic [DATA_W-1:0] opnd);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = opnd;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(evaluate_token(act, opnd));
    if (act <= pese_pkg::ACT_FINISH) tokens_sent++;
  endtask

  // Receiver: random stalls plus long holds on request
  always @(negedge clk) begin
    if (rx_hold_request > 0) begin
      rx_stall_left   = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_stall_left > 0) begin
      m_tready = 1'b0;
      rx_stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      m_tready      = 1'b0;
      rx_stall_left = pick_gap();
    end else begin
      m_tready = 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: value %h status %0d last %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        mismatch_seen = 1'b1;
      end else begin
        rx_want = pending_results.pop_front();
        if (m_tuser !== rx_want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, rx_want.status, m_tuser);
          mismatch_seen = 1'b1;
        end
        if (m_tdata !== rx_want.value) begin
          $display("%0t: value mismatch: expected %h, actual %h",
                   $time, rx_want.value, m_tdata);
          mismatch_seen = 1'b1;
        end
        if (m_tlast !== rx_want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, rx_want.last, m_tlast);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Pops from an empty stack, including a finish and a half-empty operator
  task automatic test_empty_stack();
    send_token(pese_pkg::ACT_FINISH, $urandom);
    send_token(pese_pkg::ACT_ADD, $urandom);
    send_token(pese_pkg::ACT_FINISH, '0);
    send_token(pese_pkg::ACT_PUSH, DATA_W'(5));
    send_token(pese_pkg::ACT_MUL, '0);
    send_token(pese_pkg::ACT_FINISH, '0);
  endtask

  // Wrapping add, subtract and multiply on extreme operands
  task automatic test_wrapping_arithmetic();
    send_token(pese_pkg::ACT_PUSH, DATA_W'(1));
    send_token(pese_pkg::ACT_PUSH, WORD_MAX);
    send_token(pese_pkg::ACT_ADD, '0);
    send_token(pese_pkg::ACT_PUSH, DATA_W'(7));
    send_token(pese_pkg::ACT_PUSH, WORD_MIN);
    send_token(pese_pkg::ACT_SUB, '0);
    send_token(pese_pkg::ACT_PUSH, DATA_W'(65536));
    send_token(pese_pkg::ACT_PUSH, WORD_M1);
    send_token(pese_pkg::ACT_MUL, '0);
  endtask

  // Truncation toward zero, most negative over minus one, a zero divisor and a zero dividend
  task automatic test_division();
    send_token(pese_pkg::ACT_PUSH, DATA_W'(2));
    send_token(pese_pkg::ACT_PUSH, -DATA_W'(7));
    send_token(pese_pkg::ACT_DIV, '0);
    send_token(pese_pkg::ACT_PUSH, WORD_M1);
    send_token(pese_pkg::ACT_PUSH, WORD_MIN);
    send_token(pese_pkg::ACT_DIV, '0);
    send_token(pese_pkg::ACT_PUSH, '0);
    send_token(pese_pkg::ACT_PUSH, DATA_W'(9));
    send_token(pese_pkg::ACT_DIV, '0);
    send_token(pese_pkg::ACT_DIV, '0);
  endtask

  // Unknown actions leave the stack alone; finish takes only the top entry
  task automatic test_unknown_and_leftovers();
    send_token(ACT_UNUSED_LO, WORD_M1);
    send_token(ACT_UNUSED_HI, $urandom);
    send_token(pese_pkg::ACT_FINISH, '0);
    send_token(pese_pkg::ACT_FINISH, '0);
  endtask

  // Hold the receiver while pushing past a full stack, then drain it
  task automatic test_full_stack_backpressure();
    int n_push;
    tx_idle_on      = 1'b0;
    rx_hold_request = 300;
    n_push = STACK_DEPTH - model_depth + 2;
    repeat (n_push) send_token(pese_pkg::ACT_PUSH, pick_operand());
    while (model_depth > 0) send_token(pese_pkg::ACT_FINISH, '0);
    send_token(pese_pkg::ACT_FINISH, '0);
  endtask

  // Well-formed expressions with random shape and content, plus noise
  task automatic test_random_expressions(int n_tokens);
    int               ops_left, leaves_left, depth, room;
    bit               do_op;
    logic [ACT_W-1:0] act;
    while (tokens_sent < n_tokens) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 99) < 15) begin
        // noise: any action, any operand
        act = ACT_W'($urandom_range(0, 7));
        send_token(act, pick_operand());
      end else begin
        // keep headroom for the expression on top of leftovers
        while (model_depth > 20) send_token(pese_pkg::ACT_FINISH, '0);
        ops_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 11)
                                                  : $urandom_range(1, 5);
        leaves_left = ops_left + 1;
        depth       = 0;
        room        = STACK_DEPTH - model_depth;
        while (ops_left > 0 || leaves_left > 0) begin
          if (depth < 2 || ops_left == 0)
            do_op = 1'b0;
          else if (leaves_left == 0 || depth >= room)
            do_op = 1'b1;
          else
            do_op = $urandom_range(0, 1);
          if (do_op) begin
            act = ACT_W'($urandom_range(pese_pkg::ACT_ADD, pese_pkg::ACT_DIV));
            send_token(act, $urandom);
            ops_left--;
            depth--;
          end else begin
            send_token(pese_pkg::ACT_PUSH, pick_operand());
            leaves_left--;
            depth++;
          end
        end
        // occasionally leave the value behind
        if ($urandom_range(0, 9) != 0) send_token(pese_pkg::ACT_FINISH, $urandom);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_stack();
    test_wrapping_arithmetic();
    test_division();
    test_unknown_and_leftovers();
    test_full_stack_backpressure();
    test_random_expressions(tokens_sent + 400);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (!mismatch_seen) begin
      $display("prefix_expression_stack_evaluator_test passed");
    end else begin
      $display("prefix_expression_stack_evaluator_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("prefix_expression_stack_evaluator_test failed");
    $finish;
  end

endmodule

### filelist.f
src/pese_pkg.sv
src/pese_div.sv
src/pese_ctrl.sv
src/pese_dp.sv
src/prefix_expression_stack_evaluator.sv
src/pese_checker.sv
test/prefix_expression_stack_evaluator_test.sv
